### rtl/core/vfc_pkg.sv
// voxel face cull mesher: shared types and constants
// no dependencies
`default_nettype none

package vfc_pkg;

  localparam int CUBE_EDGE  = 16;
  localparam int COORD_W    = 4;
  localparam int DEPTH      = CUBE_EDGE * CUBE_EDGE * CUBE_EDGE;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = 17;
  localparam int DIR_W      = 3;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_MESH  = 1'b1;

  localparam logic [DIR_W-1:0] DIR_PX = 3'd0;
  localparam logic [DIR_W-1:0] DIR_NX = 3'd1;
  localparam logic [DIR_W-1:0] DIR_PY = 3'd2;
  localparam logic [DIR_W-1:0] DIR_NY = 3'd3;
  localparam logic [DIR_W-1:0] DIR_PZ = 3'd4;
  localparam logic [DIR_W-1:0] DIR_NZ = 3'd5;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] pos_z;
    logic               solid;
    logic               restart;
  } vfc_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] face_x;
    logic [COORD_W-1:0] face_y;
    logic [COORD_W-1:0] face_z;
    logic [DIR_W-1:0]   face_dir;
    logic [CNT_W-1:0]   base_vertex;
    logic               last;
  } vfc_out_t;

  // linear store address, x fastest
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] y,
                                                  input logic [COORD_W-1:0] z);
    int a;
    a = (int'(z) * CUBE_EDGE + int'(y)) * CUBE_EDGE + int'(x);
    return ADDR_W'(a);
  endfunction

  function automatic logic coord_out(input logic [COORD_W:0] c);
    return c >= (COORD_W+1)'(CUBE_EDGE);
  endfunction

endpackage

`default_nettype wire

### rtl/core/voxel_face_cull_mesher_top.sv
// voxel face cull mesher top level: voxel store, neighbor sequencer, record output
// depends on vfc_pkg
`default_nettype none

// Usage:
//  An item is taken at a rising edge with start high and busy low (item_i).
//  A write item (kind 0) stores one voxel bit; busy stays low.
//  A mesh item (kind 1) reads the named voxel, then its six neighbors in the
//  order +x, -x, +y, -y, +z, -z, one store read per cycle through the single
//  registered read port, with one shared increment/decrement unit forming the
//  neighbor coordinate. Each exposed face gives one record on res_o, marked by
//  res_valid_o for one cycle; the receiver cannot stall the block.
//  One face record is held back until the next exposed face or the end of the
//  scan so that the final record can carry last.
//  Busy stays high for each mesh item until its scan ends, which comes early
//  when the voxel is air; records leave while the scan runs, the last one in
//  the cycle the block drops busy.
//  Reset: the vertex counter clears at once, then a clearing pass writes air
//  to all 4096 store entries, one per cycle, with busy held high.

module voxel_face_cull_mesher_top
  import vfc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire vfc_in_t  item_i,
  output logic          res_valid_o,
  output vfc_out_t      res_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CLEAR = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  localparam logic [2:0] STEP_CENTER = 3'd0;
  localparam logic [2:0] STEP_FLUSH  = 3'd7;

  logic [1:0]        state_q, state_d;
  logic [2:0]        step_q, step_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  vfc_in_t           item_q, item_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  vfc_out_t          pend_q, pend_d;
  logic              pend_v_q, pend_v_d;
  logic              oside_q, oside_d;
  logic              res_valid_q, res_valid_d;
  vfc_out_t          res_q, res_d;

  logic              rd_q;
  logic [ADDR_W-1:0] rd_addr;
  logic              we;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_data;

  logic              accept;
  logic              solid_rd;

  // shared neighbor unit
  logic [1:0]         nb_axis;
  logic               nb_neg;
  logic [COORD_W-1:0] nb_sel;
  logic [COORD_W:0]   nb_sum;
  logic [COORD_W-1:0] nb_x, nb_y, nb_z;
  logic               ctr_out;

  logic [COORD_W-1:0] mem_x, mem_y, mem_z;

  logic mem_q [DEPTH];

  assign accept   = start && !busy;
  assign busy     = (state_q != ST_IDLE);
  assign solid_rd = rd_q && !oside_q;

  assign nb_axis = step_q[2:1];
  assign nb_neg  = step_q[0];

  always_comb begin
    nb_x = item_q.pos_x;
    nb_y = item_q.pos_y;
    nb_z = item_q.pos_z;
    case (nb_axis)
      2'd0:    nb_sel = item_q.pos_x;
      2'd1:    nb_sel = item_q.pos_y;
      2'd2:    nb_sel = item_q.pos_z;
      default: nb_sel = item_q.pos_z;
    endcase
    nb_sum = {1'b0, nb_sel} + (nb_neg ? {(COORD_W+1){1'b1}} : (COORD_W+1)'(1));
    case (nb_axis)
      2'd0:    nb_x = nb_sum[COORD_W-1:0];
      2'd1:    nb_y = nb_sum[COORD_W-1:0];
      2'd2:    nb_z = nb_sum[COORD_W-1:0];
      default: nb_z = item_q.pos_z;
    endcase
  end

  assign ctr_out = coord_out({1'b0, item_i.pos_x}) || coord_out({1'b0, item_i.pos_y}) ||
                   coord_out({1'b0, item_i.pos_z});

  // the center read goes out in the accept cycle, neighbors while running
  assign mem_x   = busy ? nb_x : item_i.pos_x;
  assign mem_y   = busy ? nb_y : item_i.pos_y;
  assign mem_z   = busy ? nb_z : item_i.pos_z;
  assign rd_addr = cell_addr(mem_x, mem_y, mem_z);

  always_comb begin
    we      = 1'b0;
    wr_addr = cell_addr(item_i.pos_x, item_i.pos_y, item_i.pos_z);
    wr_data = item_i.solid;
    if (state_q == ST_CLEAR) begin
      we      = 1'b1;
      wr_addr = clr_q;
      wr_data = 1'b0;
    end else if (accept && item_i.kind == KIND_WRITE && !ctr_out) begin
      we = 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    clr_d       = clr_q;
    item_d      = item_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    pend_v_d    = pend_v_q;
    oside_d     = oside_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && item_i.kind == KIND_MESH) begin
          item_d   = item_i;
          oside_d  = ctr_out;
          step_d   = STEP_CENTER;
          pend_v_d = 1'b0;
          state_d  = ST_RUN;
          if (item_i.restart) begin
            cnt_d = '0;
          end
        end
      end
      ST_RUN: begin
        oside_d = coord_out(nb_sum);
        step_d  = step_q + 3'd1;
        if (step_q == STEP_CENTER) begin
          if (!solid_rd) begin
            state_d = ST_IDLE;
          end
        end else if (step_q == STEP_FLUSH) begin
          if (pend_v_q) begin
            res_valid_d = 1'b1;
            res_d       = pend_q;
            res_d.last  = 1'b1;
          end
          pend_v_d = 1'b0;
          state_d  = ST_IDLE;
        end else if (!solid_rd) begin
          // exposed face: release the held record, hold this one
          if (pend_v_q) begin
            res_valid_d = 1'b1;
            res_d       = pend_q;
          end
          pend_d.face_x      = item_q.pos_x;
          pend_d.face_y      = item_q.pos_y;
          pend_d.face_z      = item_q.pos_z;
          pend_d.face_dir    = DIR_W'(step_q - 3'd1);
          pend_d.base_vertex = cnt_q;
          pend_d.last        = 1'b0;
          pend_v_d           = 1'b1;
          cnt_d              = cnt_q + CNT_W'(4);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      step_q      <= STEP_CENTER;
      clr_q       <= '0;
      cnt_q       <= '0;
      pend_v_q    <= 1'b0;
      oside_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      pend_v_q    <= pend_v_d;
      oside_q     <= oside_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    pend_q <= pend_d;
    res_q  <= res_d;
  end

  // voxel store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_res_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(state_q == ST_RUN))
    else $error("face record outside a mesh scan");

  a_mesh_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item_i.kind == KIND_MESH) |=> busy)
    else $error("mesh transaction did not start a scan");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last) |-> !busy)
    else $error("last record while scan still running");

  a_dir_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.face_dir <= DIR_NZ))
    else $error("face direction out of range");

  a_base_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.base_vertex[1:0] == 2'b00))
    else $error("base vertex not a multiple of four");

endmodule

`default_nettype wire
